[src/assert_macros.svh]
// assertion macros for the ranger rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked property with asynchronous active-low reset as disable
`define URR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property violated");
// same-cycle implication between two conditions
`define URR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define URR_ASSERT(lbl, clk, rstn, prop)
`define URR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

[src/urr_pkg.sv]
// package: types and constants of the round robin ultrasonic ranger
package urr_pkg;

    localparam int MAX_SENSORS     = 3;
    localparam int NUM_SENSORS_DEF = 3;
    localparam int STAMP_WIDTH_DEF = 32;

    localparam int IDX_W     = 2;
    localparam int DIST_W    = 12;
    localparam int TIMEOUT_W = 16;
    localparam int TRIG_W    = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    localparam logic [DIST_W-1:0]    DIST_MAX     = 12'hFFF;
    localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX  = 16'hFFFF;

    // distance = floor(dur * 343 / 2000); dur at or above CLAMP_DUR saturates
    localparam int DUR_W       = 15;
    localparam int CLAMP_DUR   = 23884;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_K = 24'd11509171;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 16'd13746;
    localparam logic [TRIG_W-1:0]    TRIG_RST     = 8'd10;
    localparam logic [DIST_W-1:0]    MIN_DIST_RST = 12'd20;
    localparam logic [DIST_W-1:0]    MAX_DIST_RST = 12'd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT    = 8'd0,
        REG_TRIG_WIDTH = 8'd1,
        REG_MIN_DIST   = 8'd2,
        REG_MAX_DIST   = 8'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout;
        logic [TRIG_W-1:0]    trig_width;
        logic [DIST_W-1:0]    min_dist;
        logic [DIST_W-1:0]    max_dist;
    } cfg_t;

    // top to one echo channel
    typedef struct packed {
        logic clear_reading;
        logic clear_rise;
    } chan_ctrl_t;

    // one echo channel to top, reading fields are post-tick values
    typedef struct packed {
        logic              done;
        logic              new_reading;
        logic              valid;
        logic [DIST_W-1:0] distance;
    } chan_stat_t;

    typedef struct packed {
        logic [IDX_W-1:0]       active;
        logic [IDX_W-1:0]       active_next;
        logic                   advance;
        logic                   timeout_clear;
        logic [MAX_SENSORS-1:0] trig_next;
    } slot_stat_t;

endpackage

[src/ultrasonic_round_robin_ranger.sv]
// top level of the round robin ultrasonic ranger
//
// usage: one transfer on the s_ group is one microsecond tick carrying the
// echo levels of up to three sensors. every accepted tick produces exactly
// one transfer on the m_ group with the trigger drive, the three stored
// distances, the valid mask, the active sensor and the new-reading mask,
// all taken after that tick's update.
// path: an accepted tick waits in the input register, and its result is
// loaded into the output register, which drives m_tdata.
// throughput: one tick per cycle unless a waiting result is held by m_tready;
// the whole tick update sits between the input register and the output
// register, with one 15x24 constant multiply in the echo channel as the longest path.
// stalls: while m_tready is low and a result waits, the input register
// still takes one more tick, then s_tready drops; no tick is dropped.
// reset: sensor 0 is active with its trigger pulse loaded, all readings
// zero and invalid, configuration at its defaults, both stages empty.
// configuration: cfg_ready is always high; write only while idle.
`include "assert_macros.svh"

module ultrasonic_round_robin_ranger #(
    parameter int NUM_SENSORS = urr_pkg::NUM_SENSORS_DEF,
    parameter int STAMP_WIDTH = urr_pkg::STAMP_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input ticks
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [urr_pkg::IN_DATA_W-1:0]  s_tdata,   // [2:0] echo_levels, rest zero
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [2:0] trigger_lines, [14:3] distance_zero, [26:15] distance_one,
    // [38:27] distance_two, [41:39] valid_mask, [43:42] active_sensor,
    // [46:44] new_reading_mask, [47] zero
    output logic [urr_pkg::OUT_DATA_W-1:0] m_tdata,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [urr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import urr_pkg::*;

    // field offsets inside m_tdata
    localparam int O_D0    = MAX_SENSORS;
    localparam int O_D1    = O_D0 + DIST_W;
    localparam int O_D2    = O_D1 + DIST_W;
    localparam int O_VALID = O_D2 + DIST_W;
    localparam int O_ACT   = O_VALID + MAX_SENSORS;
    localparam int O_NEW   = O_ACT + IDX_W;

    cfg_t cfg;

    // input stage
    logic                   in_valid_reg;
    logic [MAX_SENSORS-1:0] echo_reg;

    // output stage
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;

    logic                   out_free;
    logic                   step;

    logic [STAMP_WIDTH-1:0] tick_reg;

    chan_ctrl_t             chan_ctrl [MAX_SENSORS];
    chan_stat_t             chan_stat [MAX_SENSORS];
    logic [MAX_SENSORS-1:0] done_active;
    logic                   active_done;
    slot_stat_t             slot;

    logic [MAX_SENSORS-1:0] valid_mask;
    logic [MAX_SENSORS-1:0] new_mask;

    // a tick is processed when the output register can take its result
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    urr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // one echo channel per fitted sensor; sensors beyond read as zero
    for (genvar k = 0; k < MAX_SENSORS; k++)
    begin : g_chan
        if (k < NUM_SENSORS)
        begin : g_used
            assign chan_ctrl[k].clear_reading = slot.timeout_clear
                                             && (slot.active == IDX_W'(k));
            assign chan_ctrl[k].clear_rise    = slot.advance
                                             && (slot.active_next == IDX_W'(k));

            urr_echo_chan #(
                .STAMP_WIDTH (STAMP_WIDTH)
            ) u_chan (
                .clk        (clk),
                .rst_n      (rst_n),
                .step       (step),
                .echo       (echo_reg[k]),
                .tick_count (tick_reg),
                .cfg        (cfg),
                .ctrl       (chan_ctrl[k]),
                .stat       (chan_stat[k])
            );
        end
        else
        begin : g_unused
            assign chan_ctrl[k] = '0;
            assign chan_stat[k] = '0;
        end

        // only the active sensor's echo completion moves the slot on
        assign done_active[k] = chan_stat[k].done && (slot.active == IDX_W'(k));
        assign valid_mask[k]  = chan_stat[k].valid;
        assign new_mask[k]    = chan_stat[k].new_reading;
    end

    assign active_done = |done_active;

    urr_slot_ctrl #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_slot (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .active_done (active_done),
        .cfg         (cfg),
        .stat        (slot)
    );

    always_comb
    begin
        out_data_next                            = '0;
        out_data_next[MAX_SENSORS-1:0]           = slot.trig_next;
        out_data_next[O_D0 +: DIST_W]            = chan_stat[0].distance;
        out_data_next[O_D1 +: DIST_W]            = chan_stat[1].distance;
        out_data_next[O_D2 +: DIST_W]            = chan_stat[2].distance;
        out_data_next[O_VALID +: MAX_SENSORS]    = valid_mask;
        out_data_next[O_ACT +: IDX_W]            = slot.active_next;
        out_data_next[O_NEW +: MAX_SENSORS]      = new_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
            begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_reg + 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            echo_reg <= s_tdata[MAX_SENSORS-1:0];
        if (step)
            out_data_reg <= out_data_next;
    end

    // checks
    `URR_ASSERT(a_active_in_range, clk, rst_n, (slot.active < IDX_W'(NUM_SENSORS)))
    `URR_ASSERT_IMPL(a_trig_onehot, clk, rst_n, m_tvalid, $onehot0(m_tdata[MAX_SENSORS-1:0]))
    `URR_ASSERT_IMPL(a_invalid_reads_zero, clk, rst_n, m_tvalid && !m_tdata[O_VALID], m_tdata[O_D0 +: DIST_W] == '0)
    `URR_ASSERT(a_step_fills_output, clk, rst_n, step |=> m_tvalid)

endmodule

[src/urr_cfg_regs.sv]
// configuration register file of the ranger
module urr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [urr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [urr_pkg::CFG_DATA_W-1:0] cfg_data,
    output urr_pkg::cfg_t                  cfg
);
    import urr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TIMEOUT:    cfg_next.timeout    = cfg_data[TIMEOUT_W-1:0];
                REG_TRIG_WIDTH: cfg_next.trig_width = cfg_data[TRIG_W-1:0];
                REG_MIN_DIST:   cfg_next.min_dist   = cfg_data[DIST_W-1:0];
                REG_MAX_DIST:   cfg_next.max_dist   = cfg_data[DIST_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout    <= TIMEOUT_RST;
            cfg_reg.trig_width <= TRIG_RST;
            cfg_reg.min_dist   <= MIN_DIST_RST;
            cfg_reg.max_dist   <= MAX_DIST_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/urr_dist_calc.sv]
// echo duration to distance in mm, with clamp and range check
module urr_dist_calc #(
    parameter int STAMP_WIDTH = urr_pkg::STAMP_WIDTH_DEF
) (
    input  logic [STAMP_WIDTH-1:0]     duration,
    input  logic [urr_pkg::DIST_W-1:0] min_dist,
    input  logic [urr_pkg::DIST_W-1:0] max_dist,
    output logic [urr_pkg::DIST_W-1:0] distance,
    output logic                       valid
);
    import urr_pkg::*;

    logic                       clamp;
    logic [DUR_W-1:0]           dur_short;
    logic [DUR_W+RECIP_W-1:0]   prod;
    logic [DIST_W-1:0]          dist_raw;

    // constant reciprocal of 2000/343, exact floor for all durations below clamp
    assign clamp     = duration >= STAMP_WIDTH'(CLAMP_DUR);
    assign dur_short = duration[DUR_W-1:0];
    assign prod      = {{RECIP_W{1'b0}}, dur_short} * {{DUR_W{1'b0}}, RECIP_K};
    assign dist_raw  = clamp ? DIST_MAX : prod[RECIP_SHIFT +: DIST_W];

    assign valid    = (dist_raw >= min_dist) && (dist_raw <= max_dist);
    assign distance = valid ? dist_raw : '0;

endmodule

[src/urr_echo_chan.sv]
// one sensor: echo edge detect, rise stamp and stored reading
module urr_echo_chan #(
    parameter int STAMP_WIDTH = urr_pkg::STAMP_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   echo,
    input  logic [STAMP_WIDTH-1:0] tick_count,
    input  urr_pkg::cfg_t          cfg,
    input  urr_pkg::chan_ctrl_t    ctrl,
    output urr_pkg::chan_stat_t    stat
);
    import urr_pkg::*;

    logic                   echo_prev_reg;
    logic                   rise_seen_reg;
    logic                   rise_seen_next;
    logic [STAMP_WIDTH-1:0] stamp_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [DIST_W-1:0]      dist_next;
    logic                   valid_reg;
    logic                   valid_next;

    logic                   rise;
    logic                   fall;
    logic [STAMP_WIDTH-1:0] duration;
    logic [DIST_W-1:0]      calc_dist;
    logic                   calc_valid;

    assign rise     = echo && !echo_prev_reg;
    assign fall     = !echo && echo_prev_reg && rise_seen_reg;
    assign duration = tick_count - stamp_reg;

    urr_dist_calc #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_calc (
        .duration (duration),
        .min_dist (cfg.min_dist),
        .max_dist (cfg.max_dist),
        .distance (calc_dist),
        .valid    (calc_valid)
    );

    always_comb
    begin
        rise_seen_next = rise_seen_reg;
        if (rise)
            rise_seen_next = 1'b1;
        else if (fall)
            rise_seen_next = 1'b0;
        // slot handover drops a half-seen echo on the new sensor
        if (ctrl.clear_rise)
            rise_seen_next = 1'b0;

        dist_next  = dist_reg;
        valid_next = valid_reg;
        if (fall)
        begin
            dist_next  = calc_dist;
            valid_next = calc_valid;
        end
        if (ctrl.clear_reading)
        begin
            dist_next  = '0;
            valid_next = 1'b0;
        end
    end

    assign stat.done        = fall;
    assign stat.new_reading = fall || ctrl.clear_reading;
    assign stat.valid       = valid_next;
    assign stat.distance    = dist_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_prev_reg <= 1'b0;
            rise_seen_reg <= 1'b0;
            dist_reg      <= '0;
            valid_reg     <= 1'b0;
        end
        else if (step)
        begin
            echo_prev_reg <= echo;
            rise_seen_reg <= rise_seen_next;
            dist_reg      <= dist_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && rise)
            stamp_reg <= tick_count;
    end

endmodule

[src/urr_slot_ctrl.sv]
// round robin slot: active index, timeout counter and trigger pulse
module urr_slot_ctrl #(
    parameter int NUM_SENSORS = urr_pkg::NUM_SENSORS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                active_done,
    input  urr_pkg::cfg_t       cfg,
    output urr_pkg::slot_stat_t stat
);
    import urr_pkg::*;

    logic [IDX_W-1:0]     active_reg;
    logic [IDX_W-1:0]     active_next;
    logic [TIMEOUT_W-1:0] elapsed_reg;
    logic [TIMEOUT_W-1:0] elapsed_next;
    logic [TRIG_W-1:0]    pulse_reg;
    logic [TRIG_W-1:0]    pulse_next;

    logic [TIMEOUT_W-1:0]   elapsed_inc;
    logic [TRIG_W-1:0]      pulse_load;
    logic                   advance;
    logic                   pulse_on;
    logic [MAX_SENSORS-1:0] trig_next;

    always_comb
    begin
        elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        advance     = active_done || (elapsed_inc >= cfg.timeout);

        active_next = active_reg;
        if (advance)
            active_next = (active_reg == IDX_W'(NUM_SENSORS - 1)) ? '0 : active_reg + 1'b1;

        elapsed_next = advance ? '0 : elapsed_inc;
        pulse_load   = advance ? cfg.trig_width : pulse_reg;
        pulse_on     = pulse_load != '0;
        pulse_next   = pulse_on ? pulse_load - 1'b1 : pulse_load;
    end

    always_comb
    begin
        for (int j = 0; j < MAX_SENSORS; j++)
            trig_next[j] = pulse_on && (active_next == IDX_W'(j));
    end

    assign stat.trig_next     = trig_next;
    assign stat.active        = active_reg;
    assign stat.active_next   = active_next;
    assign stat.advance       = advance;
    assign stat.timeout_clear = advance && !active_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            elapsed_reg <= '0;
            pulse_reg   <= TRIG_RST;
        end
        else if (step)
        begin
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            pulse_reg   <= pulse_next;
        end
    end

endmodule

[sim/ultrasonic_round_robin_ranger_tb.sv]
// testbench of the round robin ultrasonic ranger: directed and random ticks against a predictor
module ultrasonic_round_robin_ranger_tb;

    import urr_pkg::*;

    // generous bound: the long clamp echo plus the random traffic, all of it
    // at the worst idle and stall draws, several times over
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_TICKS  = 1400;
    localparam int SENSORS       = 3;

    // one result transfer, field by field
    typedef struct {
        logic [2:0]        trig;
        logic [DIST_W-1:0] dist0;
        logic [DIST_W-1:0] dist1;
        logic [DIST_W-1:0] dist2;
        logic [2:0]        valid_mask;
        logic [IDX_W-1:0]  active;
        logic [2:0]        new_mask;
    } reading_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the register file
    logic [TIMEOUT_W-1:0]  cfg_timeout;
    logic [TRIG_W-1:0]     cfg_trig_width;
    logic [DIST_W-1:0]     cfg_min_dist;
    logic [DIST_W-1:0]     cfg_max_dist;

    // predictor copy of the ranging state
    logic [31:0]           tick_cnt;
    logic [31:0]           rise_time [SENSORS];
    logic                  rise_armed [SENSORS];
    logic                  echo_prev [SENSORS];
    logic [IDX_W-1:0]      slot;
    logic [TIMEOUT_W-1:0]  elapsed;
    logic [TRIG_W-1:0]     pulse_left;
    logic [DIST_W-1:0]     dist_mm [SENSORS];
    logic                  dist_ok [SENSORS];

    reading_t              expected_readings [$];

    int                    fail_count;
    int                    ticks_sent;
    int                    settings_used;
    int                    echoes_measured;
    int                    slot_timeouts;
    int                    cycle_count;
    int                    rx_wait;
    bit                    tx_idle;
    bit                    rx_idle;

    ultrasonic_round_robin_ranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [2:0] echo_levels
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // [2:0] trigger_lines, [14:3] distance_zero, [26:15] distance_one,
        // [38:27] distance_two, [41:39] valid_mask, [43:42] active_sensor,
        // [46:44] new_reading_mask
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("** ultrasonic_round_robin_ranger: FAILED **");
            $finish;
        end
    end

    // one microsecond tick of the ranger: echo edges, slot timing, trigger pulse
    task automatic step_ranger(input logic [2:0] echo, output reading_t r);
        logic [2:0]  fresh;
        logic        slot_done;
        logic [31:0] span;
        logic [63:0] mm;
        logic [2:0]  trig;
        fresh     = '0;
        slot_done = 1'b0;
        trig      = '0;
        for (int k = 0; k < SENSORS; k++)
        begin
            if (echo[k] && !echo_prev[k])
            begin
                rise_time[k]  = tick_cnt;
                rise_armed[k] = 1'b1;
            end
            else if (!echo[k] && echo_prev[k] && rise_armed[k])
            begin
                // duration wraps with the stamp counter
                span          = tick_cnt - rise_time[k];
                rise_armed[k] = 1'b0;
                mm            = ({32'd0, span} * 64'd343) / 64'd2000;
                if (mm > 64'd4095)
                    mm = 64'd4095;
                if (mm >= cfg_min_dist && mm <= cfg_max_dist)
                begin
                    dist_mm[k] = mm[DIST_W-1:0];
                    dist_ok[k] = 1'b1;
                end
                else
                begin
                    dist_mm[k] = '0;
                    dist_ok[k] = 1'b0;
                end
                fresh[k] = 1'b1;
                echoes_measured++;
                if (k == slot)
                    slot_done = 1'b1;
            end
            echo_prev[k] = echo[k];
        end

        if (elapsed != ELAPSED_MAX)
            elapsed++;

        if (slot_done || elapsed >= cfg_timeout)
        begin
            // abandoned sensor loses its reading; a completed one already moved on
            if (!slot_done)
            begin
                dist_mm[slot] = '0;
                dist_ok[slot] = 1'b0;
                fresh[slot]   = 1'b1;
                slot_timeouts++;
            end
            slot             = (slot == SENSORS - 1) ? '0 : slot + 1'b1;
            rise_armed[slot] = 1'b0;
            elapsed          = '0;
            pulse_left       = cfg_trig_width;
        end

        if (pulse_left != 0)
        begin
            trig = 3'b001 << slot;
            pulse_left--;
        end

        tick_cnt++;

        r.trig       = trig;
        r.dist0      = dist_mm[0];
        r.dist1      = dist_mm[1];
        r.dist2      = dist_mm[2];
        r.valid_mask = {dist_ok[2], dist_ok[1], dist_ok[0]};
        r.active     = slot;
        r.new_mask   = fresh;
    endtask

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // predict on every accepted tick, check every accepted result
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                step_ranger(s_tdata[2:0], want);
                expected_readings.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
                if (expected_readings.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compare_field("trigger_lines",    want.trig,       m_tdata[2:0]);
                    compare_field("distance_zero",    want.dist0,      m_tdata[14:3]);
                    compare_field("distance_one",     want.dist1,      m_tdata[26:15]);
                    compare_field("distance_two",     want.dist2,      m_tdata[38:27]);
                    compare_field("valid_mask",       want.valid_mask, m_tdata[41:39]);
                    compare_field("active_sensor",    want.active,     m_tdata[43:42]);
                    compare_field("new_reading_mask", want.new_mask,   m_tdata[46:44]);
                end
            end
        end
    end

    // result side: a random stall before each result when idling is on
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_tready = 1'b0;
            else if (rx_wait != 0)
            begin
                m_tready = 1'b0;
                rx_wait--;
            end
            else
                m_tready = 1'b1;
        end
    end

    // one tick transfer; entered and left at a falling edge, tvalid stays high
    task automatic send_tick(input logic [2:0] echo);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{(IN_DATA_W-3){1'b0}}, echo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    // quiet lead, echo held high for width ticks, then the falling tick
    task automatic send_echo(input logic [2:0] mask, input int lead, input int width);
        repeat (lead) send_tick(3'b000);
        repeat (width) send_tick(mask);
        send_tick(3'b000);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (expected_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        case (idx)
            REG_TIMEOUT:    cfg_timeout    = value[TIMEOUT_W-1:0];
            REG_TRIG_WIDTH: cfg_trig_width = value[TRIG_W-1:0];
            REG_MIN_DIST:   cfg_min_dist   = value[DIST_W-1:0];
            REG_MAX_DIST:   cfg_max_dist   = value[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input logic [15:0] to, input logic [7:0] tw,
                               input logic [11:0] lo, input logic [11:0] hi);
        drain_results();
        write_reg(REG_TIMEOUT, to);
        write_reg(REG_TRIG_WIDTH, {8'd0, tw});
        write_reg(REG_MIN_DIST, {4'd0, lo});
        write_reg(REG_MAX_DIST, {4'd0, hi});
        settings_used++;
    endtask

    // defaults: trigger pulse on sensor 0, reading right at the lower window edge
    task automatic test_reset_defaults();
        repeat (12) send_tick(3'b000);
        send_echo(3'b001, 2, 117);      // 20 mm, valid at min
        send_echo(3'b010, 3, 116);      // 19 mm, below the window
    endtask

    // widest pulse, longest timeout, full window, zero and clamped distances
    task automatic test_register_extremes();
        apply_setup(16'hFFFF, 8'hFF, 12'd0, 12'd4095);
        send_echo(3'b001 << slot, 260, 1);      // one tick duration reads 0 mm
        send_echo(3'b001 << slot, 3, 24000);    // saturates at 4095 mm
    endtask

    // single-value window and an empty window
    task automatic test_distance_window();
        apply_setup(16'd2000, 8'd4, 12'd34, 12'd34);
        send_echo(3'b001 << slot, 1, 198);      // 33 mm
        send_echo(3'b001 << slot, 1, 200);      // 34 mm
        send_echo(3'b001 << slot, 1, 204);      // 34 mm
        send_echo(3'b001 << slot, 1, 205);      // 35 mm
        apply_setup(16'd2000, 8'd4, 12'd4095, 12'd0);
        send_echo(3'b001 << slot, 1, 200);      // nothing is valid
    endtask

    // zero timeout moves the slot every tick, zero width drives no pulse
    task automatic test_fast_slot_rotation();
        apply_setup(16'd0, 8'd0, 12'd0, 12'd4095);
        for (int i = 0; i < 8; i++)
            send_tick(i[2:0]);
        apply_setup(16'd1, 8'd1, 12'd0, 12'd4095);
        for (int i = 7; i >= 0; i--)
            send_tick(i[2:0]);
    endtask

    task automatic test_echo_corner_cases();
        logic [2:0] next_bit;
        apply_setup(16'd40, 8'd5, 12'd0, 12'd4095);
        // reading from a sensor that is not active: stored, slot stays
        next_bit = 3'b001 << ((slot == SENSORS - 1) ? 0 : slot + 1);
        send_echo(next_bit, 2, 30);
        // the same echo twice flags a new reading both times
        send_echo(3'b001 << slot, 1, 60);
        send_echo(3'b001 << slot, 1, 60);
        // echo already high when its sensor becomes active: the fall is ignored
        next_bit = 3'b001 << ((slot == SENSORS - 1) ? 0 : slot + 1);
        repeat (45) send_tick(next_bit);
        send_tick(3'b000);
        // silence until the active sensor is abandoned
        repeat (50) send_tick(3'b000);
    endtask

    task automatic pick_random_setup();
        logic [15:0] to;
        logic [7:0]  tw;
        logic [11:0] lo;
        logic [11:0] hi;
        case ($urandom_range(0, 7))
            0:       to = $urandom_range(0, 3);
            1:       to = 16'hFFFF;
            default: to = $urandom_range(30, 500);
        endcase
        tw = ($urandom_range(0, 5) == 0) ? 8'hFF : $urandom_range(0, 30);
        lo = $urandom_range(0, 15);
        hi = $urandom_range(5, 30);
        if ($urandom_range(0, 5) == 0)
        begin
            lo = 12'd0;
            hi = 12'd4095;
        end
        apply_setup(to, tw, lo, hi);
    endtask

    // phases of mostly well-formed echoes on the active sensor, plus noise
    task automatic test_random_traffic();
        int         first;
        int         kind;
        int         width;
        int         quiet;
        logic [2:0] mask;
        first = ticks_sent;
        while (ticks_sent - first < RANDOM_TICKS)
        begin
            pick_random_setup();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 12))
            begin
                kind = $urandom_range(0, 9);
                if (kind < 7)
                begin
                    mask = 3'b001 << slot;
                    if ($urandom_range(0, 3) == 0)
                        mask = mask | 3'($urandom_range(0, 7));
                    width = $urandom_range(1, ($urandom_range(0, 1) != 0) ? 40 : 160);
                    send_echo(mask, $urandom_range(0, 15), width);
                end
                else if (kind == 7)
                    repeat ($urandom_range(1, 20)) send_tick(3'($urandom_range(0, 7)));
                else if (kind == 8)
                begin
                    quiet = (cfg_timeout > 298) ? 300 : cfg_timeout + 2;
                    repeat (quiet) send_tick(3'b000);
                end
                else
                    send_echo(3'($urandom_range(1, 7)), $urandom_range(0, 5),
                              $urandom_range(1, 40));
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rx_wait    = 0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        fail_count = 0;

        // predictor state as the block comes out of reset
        cfg_timeout    = TIMEOUT_RST;
        cfg_trig_width = TRIG_RST;
        cfg_min_dist   = MIN_DIST_RST;
        cfg_max_dist   = MAX_DIST_RST;
        tick_cnt       = '0;
        slot           = '0;
        elapsed        = '0;
        pulse_left     = TRIG_RST;
        for (int k = 0; k < SENSORS; k++)
        begin
            rise_time[k]  = '0;
            rise_armed[k] = 1'b0;
            echo_prev[k]  = 1'b0;
            dist_mm[k]    = '0;
            dist_ok[k]    = 1'b0;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        settings_used = 1;

        test_reset_defaults();
        test_register_extremes();
        test_distance_window();
        test_fast_slot_rotation();
        test_echo_corner_cases();
        test_random_traffic();

        drain_results();
        repeat (8) @(negedge clk);

        $display("ran %0d ticks under %0d register settings", ticks_sent, settings_used);
        $display("%0d echoes measured, %0d sensors abandoned on timeout",
                 echoes_measured, slot_timeouts);
        if (fail_count == 0)
            $display("** ultrasonic_round_robin_ranger: PASSED **");
        else
            $display("** ultrasonic_round_robin_ranger: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/urr_pkg.sv
src/urr_cfg_regs.sv
src/urr_dist_calc.sv
src/urr_echo_chan.sv
src/urr_slot_ctrl.sv
src/ultrasonic_round_robin_ranger.sv
sim/ultrasonic_round_robin_ranger_tb.sv
